>>> hdl/char_lcd_nibble_writer_unit_assert.svh
// assertion shorthands, sampled on clk and quiet while arst_n is low
`ifndef CHAR_LCD_NIBBLE_WRITER_UNIT_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITER_UNIT_ASSERT_SVH

// same-cycle implication
`define CLNW_CHECK(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("clnw check failed");

// next-cycle implication
`define CLNW_CHECK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("clnw next-cycle check failed");

`endif

>>> hdl/clnw_pkg.sv
package clnw_pkg;

	localparam int LINE_CHARS_DEF = 16;
	localparam int INIT_LEN       = 14;
	localparam int IDX_W          = 4;

	typedef logic [IDX_W-1:0] idx_t;

	// request kinds
	localparam logic [1:0] KIND_INIT = 2'd0;
	localparam logic [1:0] KIND_MSG  = 2'd1;
	localparam logic [1:0] KIND_CHAR = 2'd2;

	// line codes held in the line register
	localparam logic [1:0] LINE_NONE = 2'd0;
	localparam logic [1:0] LINE_ONE  = 2'd1;
	localparam logic [1:0] LINE_TWO  = 2'd2;

	// set-DDRAM-address command bases
	localparam logic [7:0] CMD_LINE1 = 8'h80;
	localparam logic [7:0] CMD_LINE2 = 8'hC0;

	typedef enum logic [1:0] {
		RUN_INIT,
		RUN_ADDR,
		RUN_CHAR,
		RUN_WRAP
	} run_mode_t;

	function automatic logic [3:0] init_nibble(input idx_t idx);
		logic [3:0] n;
		case (idx)
			4'd0, 4'd1, 4'd2: n = 4'h3;
			4'd3, 4'd4:       n = 4'h2;
			4'd5, 4'd7:       n = 4'h8;
			4'd9:             n = 4'h1;
			4'd11:            n = 4'h6;
			4'd13:            n = 4'hF;
			default:          n = 4'h0;
		endcase
		return n;
	endfunction

	function automatic logic [15:0] init_wait(input idx_t idx);
		logic [15:0] w;
		case (idx)
			4'd0, 4'd6:                         w = 16'd50000;
			4'd1:                               w = 16'd5000;
			4'd2, 4'd3, 4'd4, 4'd8, 4'd10, 4'd12: w = 16'd200;
			default:                            w = 16'd0;
		endcase
		return w;
	endfunction

	function automatic idx_t last_idx(input run_mode_t mode);
		idx_t l;
		case (mode)
			RUN_INIT: l = idx_t'(INIT_LEN - 1);
			RUN_WRAP: l = idx_t'(3);
			default:  l = idx_t'(1);
		endcase
		return l;
	endfunction

endpackage

>>> hdl/clnw_req_if.sv
interface clnw_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [1:0] line_select;
	logic [3:0] start_column;
	logic [7:0] char_code;

	modport source (output valid, kind, line_select, start_column, char_code, input ready);
	modport sink (input valid, kind, line_select, start_column, char_code, output ready);
endinterface

>>> hdl/clnw_xfer_if.sv
interface clnw_xfer_if;
	logic        valid;
	logic        ready;
	logic [3:0]  nibble;
	logic        register_select;
	logic [15:0] extra_wait_us;
	logic        last_of_run;

	modport source (output valid, nibble, register_select, extra_wait_us, last_of_run,
		input ready);
	modport sink (input valid, nibble, register_select, extra_wait_us, last_of_run,
		output ready);
endinterface

>>> hdl/char_lcd_nibble_writer_unit.sv
// Nibble sequencer for a two-line character LCD on a 4-bit bus.
// req (sink): one request word per handshake: kind 0 runs the 14-nibble
//   power-up sequence, kind 1 opens a message at line_select/start_column,
//   kind 2 writes char_code into the open message; kind 3 is ignored.
// xfer (source): one word per enable pulse: nibble for DB7..DB4, register
//   select, extra wait in microseconds, and last_of_run on the final word
//   of each request.
// Flow: a request is loaded into the run register when it is taken, and its
//   words pass from there to the output register. Words leave one per cycle
//   while the output is not stalled; a request holds the block until its last
//   word moves out: 14 words for init, 2 for a message start or character,
//   4 for a character that wraps to line 2. Requests with no words (character
//   with no message or past line 2, kind 3) leave the run register empty.
//   The run register and the word index that steps through it set this rate.
// A new request is taken in the cycle the last word of the previous one
//   moves into the output register, so runs follow each other with no gap.
// Reset clears the line and column state and empties both registers.
// While xfer.ready is low, a word in the output register holds and the
//   sequencer waits; req.ready is low during a run until its last word moves out.
`include "char_lcd_nibble_writer_unit_assert.svh"

module char_lcd_nibble_writer_unit #(
	parameter int LINE_CHARS = clnw_pkg::LINE_CHARS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	clnw_req_if.sink     req,
	clnw_xfer_if.source  xfer
);

	localparam int CW = $clog2(LINE_CHARS + 1);
	localparam logic [CW-1:0] LAST_COL = CW'(LINE_CHARS - 1);
	localparam logic [CW-1:0] FULL_COL = CW'(LINE_CHARS);

	// message state
	logic [1:0]    line_q;
	logic [CW-1:0] col_q;

	// run register
	logic                valid_s1;
	clnw_pkg::run_mode_t mode_s1;
	logic [7:0]          cmd_s1;
	logic [7:0]          char_s1;
	clnw_pkg::idx_t      idx_s1;

	// output register
	logic        valid_s2;
	logic [3:0]  nibble_s2;
	logic        rs_s2;
	logic [15:0] wait_s2;
	logic        last_s2;

	logic                adv;
	logic                is_last;
	logic                acc;
	logic                go;
	logic                state_we;
	clnw_pkg::run_mode_t mode_d;
	logic [7:0]          cmd_d;
	logic [1:0]          line_d;
	logic [CW-1:0]       col_d;
	logic [CW-1:0]       scol_ext;
	logic [CW-1:0]       scol_sat;
	logic [3:0]          nib_r;
	logic                rs_r;
	logic [15:0]         wait_r;

	assign adv      = !valid_s2 || xfer.ready;
	assign is_last  = (idx_s1 == clnw_pkg::last_idx(mode_s1));
	assign req.ready = !valid_s1 || (adv && is_last);
	assign acc      = req.valid && req.ready;

	assign scol_ext = CW'(req.start_column);
	assign scol_sat = (scol_ext > LAST_COL) ? LAST_COL : scol_ext;

	// decode of the request against the message state
	always_comb begin
		go       = 1'b0;
		state_we = 1'b0;
		mode_d   = clnw_pkg::RUN_CHAR;
		cmd_d    = clnw_pkg::CMD_LINE2;
		line_d   = line_q;
		col_d    = col_q;
		case (req.kind)
			clnw_pkg::KIND_INIT: begin
				go       = 1'b1;
				state_we = 1'b1;
				mode_d   = clnw_pkg::RUN_INIT;
				line_d   = clnw_pkg::LINE_NONE;
				col_d    = '0;
			end
			clnw_pkg::KIND_MSG: begin
				go       = 1'b1;
				state_we = 1'b1;
				mode_d   = clnw_pkg::RUN_ADDR;
				if (req.line_select == clnw_pkg::LINE_TWO) begin
					line_d = clnw_pkg::LINE_TWO;
					cmd_d  = {clnw_pkg::CMD_LINE2[7:4], scol_sat[3:0]};
				end else begin
					line_d = clnw_pkg::LINE_ONE;
					cmd_d  = {clnw_pkg::CMD_LINE1[7:4], scol_sat[3:0]};
				end
				col_d = scol_sat;
			end
			clnw_pkg::KIND_CHAR: begin
				if (line_q != clnw_pkg::LINE_NONE) begin
					if (col_q >= FULL_COL) begin
						// line 1 full: re-address to line 2, column 0 first
						if (line_q != clnw_pkg::LINE_TWO) begin
							go       = 1'b1;
							state_we = 1'b1;
							mode_d   = clnw_pkg::RUN_WRAP;
							line_d   = clnw_pkg::LINE_TWO;
							col_d    = CW'(1);
						end
					end else begin
						go       = 1'b1;
						state_we = 1'b1;
						mode_d   = clnw_pkg::RUN_CHAR;
						col_d    = col_q + CW'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// word selected by the run index
	always_comb begin
		nib_r  = 4'h0;
		rs_r   = 1'b0;
		wait_r = 16'd0;
		case (mode_s1)
			clnw_pkg::RUN_INIT: begin
				nib_r  = clnw_pkg::init_nibble(idx_s1);
				wait_r = clnw_pkg::init_wait(idx_s1);
			end
			clnw_pkg::RUN_ADDR: begin
				nib_r = idx_s1[0] ? cmd_s1[3:0] : cmd_s1[7:4];
			end
			clnw_pkg::RUN_CHAR: begin
				nib_r = idx_s1[0] ? char_s1[3:0] : char_s1[7:4];
				rs_r  = 1'b1;
			end
			clnw_pkg::RUN_WRAP: begin
				if (idx_s1[1]) begin
					nib_r = idx_s1[0] ? char_s1[3:0] : char_s1[7:4];
					rs_r  = 1'b1;
				end else begin
					nib_r = idx_s1[0] ? cmd_s1[3:0] : cmd_s1[7:4];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q   <= clnw_pkg::LINE_NONE;
			col_q    <= '0;
			valid_s1 <= 1'b0;
			idx_s1   <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (acc && state_we) begin
				line_q <= line_d;
				col_q  <= col_d;
			end
			if (acc) begin
				valid_s1 <= go;
				idx_s1   <= '0;
			end else if (valid_s1 && adv) begin
				// run ends once its last word has moved out
				if (is_last) begin
					valid_s1 <= 1'b0;
				end else begin
					idx_s1 <= idx_s1 + clnw_pkg::idx_t'(1);
				end
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && go) begin
			mode_s1 <= mode_d;
			cmd_s1  <= cmd_d;
			char_s1 <= req.char_code;
		end
		if (adv && valid_s1) begin
			nibble_s2 <= nib_r;
			rs_s2     <= rs_r;
			wait_s2   <= wait_r;
			last_s2   <= is_last;
		end
	end

	assign xfer.valid           = valid_s2;
	assign xfer.nibble          = nibble_s2;
	assign xfer.register_select = rs_s2;
	assign xfer.extra_wait_us   = wait_s2;
	assign xfer.last_of_run     = last_s2;

	`CLNW_CHECK(a_idx_in_run, valid_s1, idx_s1 <= clnw_pkg::last_idx(mode_s1))
	`CLNW_CHECK(a_col_range, 1'b1, col_q <= FULL_COL)
	`CLNW_CHECK(a_idle_col, line_q == clnw_pkg::LINE_NONE, col_q == '0)
	`CLNW_CHECK(a_take_on_last, acc && valid_s1, adv && is_last)
	`CLNW_CHECK_NEXT(a_last_out, valid_s1 && adv && is_last, valid_s2 && last_s2)

endmodule

>>> sim/char_lcd_nibble_writer_unit_test.sv
`timescale 1ns / 100ps

module char_lcd_nibble_writer_unit_test;

	localparam int LINE_CHARS   = clnw_pkg::LINE_CHARS_DEF;
	localparam int INIT_LEN     = clnw_pkg::INIT_LEN;
	localparam int COL_W        = $clog2(LINE_CHARS + 1);
	localparam int ITEM_TOTAL   = 380;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 24;
	localparam int HOLD_AT      = 400;
	localparam int HOLD_CYCLES  = 400;

	localparam logic [1:0] KIND_UNUSED = 2'd3;

	// power-up nibbles and the wait before each, first entry in the top bits
	localparam logic [INIT_LEN*4-1:0]  INIT_NIBS  = 56'h3332_2808_0106_0F;
	localparam logic [INIT_LEN*16-1:0] INIT_WAITS = {16'd50000, 16'd5000, 16'd200, 16'd200,
		16'd200, 16'd0, 16'd50000, 16'd0, 16'd200, 16'd0, 16'd200, 16'd0, 16'd200, 16'd0};

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] line_select;
		logic [3:0] start_column;
		logic [7:0] char_code;
	} lcd_req_t;

	typedef struct packed {
		logic [3:0]  nibble;
		logic        register_select;
		logic [15:0] extra_wait_us;
		logic        last_of_run;
	} lcd_xfer_t;

	// directed row; with use_typed the words come from nibs/rs_bits, last word lowest
	typedef struct packed {
		lcd_req_t    rq;
		bit          use_typed;
		logic [2:0]  n_typed;
		logic [15:0] nibs;
		logic [3:0]  rs_bits;
	} stim_row_t;

	typedef enum logic [1:0] {
		SINK_OPEN,
		SINK_COIN,
		SINK_SPARSE,
		SINK_COMB
	} sink_mode_t;

	logic clk;
	logic arst_n;

	clnw_req_if  req ();
	clnw_xfer_if xfer ();

	char_lcd_nibble_writer_unit #(
		.LINE_CHARS(LINE_CHARS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.xfer   (xfer)
	);

	logic [1:0]       lcd_line;
	logic [COL_W-1:0] lcd_col;
	lcd_xfer_t        run_words[$];
	lcd_xfer_t        xfer_expected[$];
	stim_row_t        stim_table[$];
	int unsigned      items_sent = 0;
	int unsigned      burst_left = 0;
	int unsigned      cycle_count = 0;
	bit               failed = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic void put_word(input logic [3:0] nib, input logic rs,
		input logic [15:0] us);
		lcd_xfer_t w;
		w.nibble = nib;
		w.register_select = rs;
		w.extra_wait_us = us;
		w.last_of_run = 1'b0;
		run_words.push_back(w);
	endfunction

	function automatic void put_addr(input logic [7:0] cmd);
		put_word(cmd[7:4], 1'b0, 16'd0);
		put_word(cmd[3:0], 1'b0, 16'd0);
	endfunction

	// words caused by one request, and the line/column it leaves behind
	function automatic void predict_run(input lcd_req_t r);
		int col;
		lcd_xfer_t w;
		run_words.delete();
		case (r.kind)
			clnw_pkg::KIND_INIT: begin
				for (int i = 0; i < INIT_LEN; i++)
					put_word(INIT_NIBS[4*(INIT_LEN-1-i) +: 4], 1'b0,
						INIT_WAITS[16*(INIT_LEN-1-i) +: 16]);
				lcd_line = clnw_pkg::LINE_NONE;
				lcd_col = '0;
			end
			clnw_pkg::KIND_MSG: begin
				col = r.start_column;
				if (col > LINE_CHARS - 1)
					col = LINE_CHARS - 1;
				lcd_line = (r.line_select == clnw_pkg::LINE_TWO) ? clnw_pkg::LINE_TWO :
					clnw_pkg::LINE_ONE;
				put_addr(((lcd_line == clnw_pkg::LINE_TWO) ? clnw_pkg::CMD_LINE2 :
					clnw_pkg::CMD_LINE1) + 8'(col));
				lcd_col = COL_W'(col);
			end
			clnw_pkg::KIND_CHAR: begin
				if (lcd_line != clnw_pkg::LINE_NONE &&
					!(lcd_line == clnw_pkg::LINE_TWO && lcd_col >= LINE_CHARS)) begin
					// line 1 full: move to line 2 first
					if (lcd_col >= LINE_CHARS) begin
						put_addr(clnw_pkg::CMD_LINE2);
						lcd_line = clnw_pkg::LINE_TWO;
						lcd_col = '0;
					end
					put_word(r.char_code[7:4], 1'b1, 16'd0);
					put_word(r.char_code[3:0], 1'b1, 16'd0);
					lcd_col = lcd_col + COL_W'(1);
				end
			end
			default: ;
		endcase
		if (run_words.size() > 0) begin
			w = run_words.pop_back();
			w.last_of_run = 1'b1;
			run_words.push_back(w);
		end
	endfunction

	task automatic add_row(input logic [1:0] kind, input logic [1:0] lsel,
		input logic [3:0] col, input logic [7:0] ch, input bit use_typed,
		input logic [2:0] n, input logic [15:0] nibs, input logic [3:0] rs);
		stim_row_t row;
		row.rq = {kind, lsel, col, ch};
		row.use_typed = use_typed;
		row.n_typed = n;
		row.nibs = nibs;
		row.rs_bits = rs;
		stim_table.push_back(row);
	endtask

	task automatic send_req(input lcd_req_t r, input bit use_typed, input int n_typed,
		input logic [15:0] nibs, input logic [3:0] rs_bits);
		lcd_xfer_t w;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if ($urandom_range(0, 3) != 0) begin
				req.valid <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
		end
		burst_left--;
		req.valid <= 1'b1;
		req.kind <= r.kind;
		req.line_select <= r.line_select;
		req.start_column <= r.start_column;
		req.char_code <= r.char_code;
		@(posedge clk);
		while (req.ready !== 1'b1)
			@(posedge clk);
		items_sent++;
		predict_run(r);
		if (use_typed) begin
			run_words.delete();
			for (int i = 0; i < n_typed; i++) begin
				w.nibble = nibs[4*(n_typed-1-i) +: 4];
				w.register_select = rs_bits[n_typed-1-i];
				w.extra_wait_us = 16'd0;
				w.last_of_run = (i == n_typed - 1);
				run_words.push_back(w);
			end
		end
		foreach (run_words[i])
			xfer_expected.push_back(run_words[i]);
	endtask

	function automatic void check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failed = 1'b1;
		end
	endfunction

	always @(posedge clk) begin : xfer_check
		lcd_xfer_t want;
		if (arst_n === 1'b1 && xfer.valid === 1'b1 && xfer.ready === 1'b1) begin
			if (xfer_expected.size() == 0) begin
				$error("word with nothing expected: nibble %h rs %b", xfer.nibble,
					xfer.register_select);
				failed = 1'b1;
			end else begin
				want = xfer_expected.pop_front();
				check_field("nibble", 16'(want.nibble), 16'(xfer.nibble));
				check_field("register_select", 16'(want.register_select),
					16'(xfer.register_select));
				check_field("extra_wait_us", want.extra_wait_us, xfer.extra_wait_us);
				check_field("last_of_run", 16'(want.last_of_run), 16'(xfer.last_of_run));
			end
		end
	end

	initial begin : sink_side
		sink_mode_t mode;
		int unsigned seg_left;
		int unsigned sink_cycles;
		bit held;
		mode = SINK_OPEN;
		seg_left = 0;
		sink_cycles = 0;
		held = 1'b0;
		xfer.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (seg_left == 0) begin
				mode = sink_mode_t'($urandom_range(0, 3));
				seg_left = $urandom_range(10, 150);
			end
			seg_left--;
			sink_cycles++;
			// one long hold-off so the block backs up into the request side
			if (!held && sink_cycles >= HOLD_AT) begin
				held = 1'b1;
				xfer.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				case (mode)
					SINK_OPEN:   xfer.ready <= 1'b1;
					SINK_COIN:   xfer.ready <= 1'($urandom_range(0, 1));
					SINK_SPARSE: xfer.ready <= ($urandom_range(0, 3) == 0);
					default:     xfer.ready <= (sink_cycles % 4 != 3);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		lcd_req_t r;
		int unsigned pick;
		int unsigned n_chars;
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.kind <= clnw_pkg::KIND_INIT;
		req.line_select <= 2'd0;
		req.start_column <= 4'd0;
		req.char_code <= 8'd0;

		// no message open after reset
		add_row(clnw_pkg::KIND_CHAR, 2'd0, 4'd0,  8'hFF, 1'b1, 3'd0, 16'h0,    4'b0000);
		add_row(KIND_UNUSED,         2'd0, 4'd0,  8'h00, 1'b1, 3'd0, 16'h0,    4'b0000);
		add_row(clnw_pkg::KIND_INIT, 2'd3, 4'd9,  8'h5A, 1'b0, 3'd0, 16'h0,    4'b0000);
		add_row(clnw_pkg::KIND_MSG,  2'd1, 4'd0,  8'h00, 1'b1, 3'd2, 16'h80,   4'b0000);
		add_row(clnw_pkg::KIND_CHAR, 2'd0, 4'd0,  8'h00, 1'b1, 3'd2, 16'h00,   4'b0011);
		add_row(clnw_pkg::KIND_CHAR, 2'd3, 4'd15, 8'hFF, 1'b1, 3'd2, 16'hFF,   4'b0011);
		// line_select 0 and 3 fall back to line 1
		add_row(clnw_pkg::KIND_MSG,  2'd0, 4'd15, 8'hFF, 1'b1, 3'd2, 16'h8F,   4'b0000);
		add_row(clnw_pkg::KIND_CHAR, 2'd1, 4'd0,  8'hA5, 1'b1, 3'd2, 16'hA5,   4'b0011);
		// line 1 full: set-address for line 2 ahead of the character
		add_row(clnw_pkg::KIND_CHAR, 2'd0, 4'd0,  8'h5A, 1'b1, 3'd4, 16'hC05A, 4'b0011);
		add_row(clnw_pkg::KIND_MSG,  2'd3, 4'd7,  8'h00, 1'b1, 3'd2, 16'h87,   4'b0000);
		add_row(clnw_pkg::KIND_MSG,  2'd2, 4'd15, 8'h00, 1'b1, 3'd2, 16'hCF,   4'b0000);
		add_row(clnw_pkg::KIND_CHAR, 2'd2, 4'd0,  8'h3C, 1'b1, 3'd2, 16'h3C,   4'b0011);
		// line 2 full: dropped
		add_row(clnw_pkg::KIND_CHAR, 2'd0, 4'd0,  8'h81, 1'b1, 3'd0, 16'h0,    4'b0000);
		add_row(KIND_UNUSED,         2'd3, 4'd15, 8'hFF, 1'b1, 3'd0, 16'h0,    4'b0000);
		add_row(clnw_pkg::KIND_MSG,  2'd2, 4'd14, 8'hFF, 1'b1, 3'd2, 16'hCE,   4'b0000);
		add_row(clnw_pkg::KIND_CHAR, 2'd1, 4'd3,  8'h12, 1'b0, 3'd0, 16'h0,    4'b0000);
		add_row(clnw_pkg::KIND_CHAR, 2'd2, 4'd5,  8'h34, 1'b0, 3'd0, 16'h0,    4'b0000);
		add_row(clnw_pkg::KIND_CHAR, 2'd0, 4'd0,  8'h56, 1'b1, 3'd0, 16'h0,    4'b0000);
		// init closes the open message
		add_row(clnw_pkg::KIND_MSG,  2'd1, 4'd2,  8'h00, 1'b0, 3'd0, 16'h0,    4'b0000);
		add_row(clnw_pkg::KIND_INIT, 2'd0, 4'd0,  8'h00, 1'b0, 3'd0, 16'h0,    4'b0000);
		add_row(clnw_pkg::KIND_CHAR, 2'd1, 4'd1,  8'h41, 1'b1, 3'd0, 16'h0,    4'b0000);
		add_row(clnw_pkg::KIND_MSG,  2'd1, 4'd15, 8'h00, 1'b1, 3'd2, 16'h8F,   4'b0000);
		add_row(clnw_pkg::KIND_CHAR, 2'd0, 4'd0,  8'h7E, 1'b1, 3'd2, 16'h7E,   4'b0011);
		add_row(clnw_pkg::KIND_CHAR, 2'd0, 4'd0,  8'hE7, 1'b1, 3'd4, 16'hC0E7, 4'b0011);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		lcd_line = clnw_pkg::LINE_NONE;
		lcd_col = '0;
		@(posedge clk);

		foreach (stim_table[i])
			send_req(stim_table[i].rq, stim_table[i].use_typed,
				int'(stim_table[i].n_typed), stim_table[i].nibs, stim_table[i].rs_bits);

		// mostly messages with a run of characters, some init and noise
		while (items_sent < ITEM_TOTAL) begin
			pick = $urandom_range(0, 99);
			r = 16'($urandom_range(0, 16'hFFFF));
			if (pick < 5) begin
				r.kind = clnw_pkg::KIND_INIT;
				send_req(r, 1'b0, 0, '0, '0);
			end else if (pick < 14) begin
				send_req(r, 1'b0, 0, '0, '0);
			end else begin
				r.kind = clnw_pkg::KIND_MSG;
				if ($urandom_range(0, 1) != 0)
					r.start_column = 4'($urandom_range(LINE_CHARS - 6, 15));
				send_req(r, 1'b0, 0, '0, '0);
				n_chars = $urandom_range(0, 2 * LINE_CHARS + 4);
				for (int i = 0; i < n_chars; i++) begin
					r = 16'($urandom_range(0, 16'hFFFF));
					r.kind = clnw_pkg::KIND_CHAR;
					send_req(r, 1'b0, 0, '0, '0);
				end
			end
		end
		req.valid <= 1'b0;

		while (xfer_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> files.f
+incdir+hdl
hdl/clnw_pkg.sv
hdl/clnw_req_if.sv
hdl/clnw_xfer_if.sv
hdl/char_lcd_nibble_writer_unit.sv
sim/char_lcd_nibble_writer_unit_test.sv
